/* src/dnia_pkg.sv */
// ----------------------------------------------------------------------------
// dnia_pkg - shared types and constants for the node-ID allocation client
// Transfer structs, configuration register codes and fixed sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package dnia_pkg;

  // Unique ID size and the widest request chunk, in bytes
  localparam int unsigned UID_LEN   = 16;
  localparam int unsigned MAX_CHUNK = 6;

  // Default timing and chunk parameters
  localparam int unsigned MIN_REQUEST_PERIOD_DEF = 600;
  localparam int unsigned FOLLOWUP_DELAY_DEF     = 400;
  localparam int unsigned CHUNK_BYTES_DEF        = 6;

  localparam logic [6:0] PREFERRED_RESET = 7'd69;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_UID_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UID_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFERRED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STATIC    = 3'd3;

  // Input item
  typedef struct packed {
    logic        mode;
    logic [31:0] now_ms;
    logic [6:0]  source_node;
    logic [4:0]  echo_len;
    logic [63:0] echo_low;
    logic [63:0] echo_high;
    logic [6:0]  granted_id;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic        send_request;
    logic [7:0]  request_head;
    logic [47:0] uid_chunk;
    logic [2:0]  chunk_len;
    logic        allocated;
    logic [6:0]  node_id;
  } out_item_t;

  // Configuration registers as seen by the step logic
  typedef struct packed {
    logic [63:0] uid_low;
    logic [63:0] uid_high;
    logic [6:0]  preferred_id;
    logic [6:0]  static_id;
  } cfg_t;

  // Allocation state
  typedef struct packed {
    logic        have_id;
    logic [6:0]  local_id;
    logic [4:0]  uid_offset;
    logic [31:0] next_request_at;
  } alloc_state_t;

endpackage

`default_nettype wire

/* src/dnia_step.sv */
// ----------------------------------------------------------------------------
// dnia_step - one allocation step
// Combinational next state and result for one tick or allocation message.
// ----------------------------------------------------------------------------
`default_nettype none

module dnia_step #(
  parameter int unsigned MIN_REQUEST_PERIOD = dnia_pkg::MIN_REQUEST_PERIOD_DEF,
  parameter int unsigned FOLLOWUP_DELAY     = dnia_pkg::FOLLOWUP_DELAY_DEF,
  parameter int unsigned CHUNK_BYTES        = dnia_pkg::CHUNK_BYTES_DEF
) (
  input  wire dnia_pkg::cfg_t         cfg,
  input  wire dnia_pkg::alloc_state_t state_i,
  input  wire dnia_pkg::in_item_t     item,
  output dnia_pkg::alloc_state_t      state_o,
  output dnia_pkg::out_item_t         result
);
  import dnia_pkg::*;

  localparam int unsigned CHUNK_LIM = (CHUNK_BYTES > MAX_CHUNK) ? MAX_CHUNK : CHUNK_BYTES;
  localparam logic [31:0] PUSH_OUT  = 32'(MIN_REQUEST_PERIOD + FOLLOWUP_DELAY);
  localparam logic [31:0] PULL_IN   = 32'(MIN_REQUEST_PERIOD);

  logic [127:0] uid_all;
  logic [127:0] echo_all;
  logic [7:0]   uid_byte [UID_LEN];
  logic         is_static;
  logic         alloc_in;
  logic [31:0]  push_out;
  logic [3:0]   off;
  logic [4:0]   left;
  logic [2:0]   clen;
  logic [3:0]   idx;
  logic [47:0]  chunk;
  logic         match;
  logic         have_nxt;

  assign uid_all  = {cfg.uid_high, cfg.uid_low};
  assign echo_all = {item.echo_high, item.echo_low};

  assign is_static = (cfg.static_id != '0);
  assign alloc_in  = is_static || state_i.have_id;
  assign push_out  = item.now_ms + PUSH_OUT;

  // Request chunk: bytes from the current offset, unused bytes zero
  assign off  = state_i.uid_offset[3:0];
  assign left = 5'(UID_LEN) - {1'b0, off};
  assign clen = (left > 5'(CHUNK_LIM)) ? 3'(CHUNK_LIM) : left[2:0];

  always_comb begin
    chunk = '0;
    idx   = '0;
    for (int k = 0; k < UID_LEN; k++) begin
      uid_byte[k] = uid_all[k*8 +: 8];
    end
    for (int i = 0; i < MAX_CHUNK; i++) begin
      idx = off + 4'(i);
      if (3'(i) < clen) begin
        chunk[i*8 +: 8] = uid_byte[idx];
      end
    end
  end

  // Echo compare over the first echo_len bytes; oversize length fails
  always_comb begin
    match = (item.echo_len <= 5'(UID_LEN));
    for (int k = 0; k < UID_LEN; k++) begin
      if ((5'(k) < item.echo_len) && (echo_all[k*8 +: 8] != uid_all[k*8 +: 8])) begin
        match = 1'b0;
      end
    end
  end

  // State update and result
  always_comb begin
    state_o = state_i;
    result  = '0;
    if (!alloc_in) begin
      if (!item.mode) begin
        if (item.now_ms >= state_i.next_request_at) begin
          state_o.next_request_at = push_out;
          state_o.uid_offset      = '0;
          result.send_request     = 1'b1;
          result.request_head     = {cfg.preferred_id, (off == '0)};
          result.uid_chunk        = chunk;
          result.chunk_len        = clen;
        end
      end else begin
        state_o.next_request_at = push_out;
        if (item.source_node == '0) begin
          state_o.uid_offset = '0;
        end else if (!match) begin
          state_o.uid_offset = '0;
        end else if (item.echo_len < 5'(UID_LEN)) begin
          state_o.uid_offset      = item.echo_len;
          state_o.next_request_at = push_out - PULL_IN;
        end else if (item.granted_id != '0) begin
          state_o.local_id = item.granted_id;
          state_o.have_id  = 1'b1;
        end
      end
    end
    have_nxt         = state_o.have_id;
    result.allocated = is_static || have_nxt;
    result.node_id   = is_static ? cfg.static_id : (have_nxt ? state_o.local_id : 7'd0);
  end

endmodule

`default_nettype wire

/* src/dynamic_node_id_allocatee_core.sv */
// ----------------------------------------------------------------------------
// dynamic_node_id_allocatee_core - dynamic node-ID allocation client
// Input register, combinational allocation step, output register.
// ----------------------------------------------------------------------------
// An accepted item is held in the input register and is stepped into the
// output register once that register is free or draining.
// Throughput: one item per cycle while the receiver accepts results; the step
// logic between the input and output registers updates the allocation state.
// Reset (rst_n low, synchronous): pipeline empty, state cleared, config
// registers to their defaults (preferred ID 69).
`default_nettype none

module dynamic_node_id_allocatee_core #(
  parameter int unsigned MIN_REQUEST_PERIOD = dnia_pkg::MIN_REQUEST_PERIOD_DEF,
  parameter int unsigned FOLLOWUP_DELAY     = dnia_pkg::FOLLOWUP_DELAY_DEF,
  parameter int unsigned CHUNK_BYTES        = dnia_pkg::CHUNK_BYTES_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  dnia_pkg::in_item_t            in_data,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output dnia_pkg::out_item_t                 out_data,
  input  wire                                 cfg_wr_en,
  input  wire  [dnia_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [dnia_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import dnia_pkg::*;

  cfg_t         cfg_r;
  alloc_state_t state_r;
  alloc_state_t state_nxt;
  in_item_t     in_r;
  logic         in_v_r;
  out_item_t    out_r;
  out_item_t    out_nxt;
  logic         out_v_r;
  logic         advance;

  // Step the held item when the output register is free or draining
  assign advance   = in_v_r && (!out_v_r || out_ready);
  assign in_ready  = !in_v_r || advance;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  dnia_step #(
    .MIN_REQUEST_PERIOD (MIN_REQUEST_PERIOD),
    .FOLLOWUP_DELAY     (FOLLOWUP_DELAY),
    .CHUNK_BYTES        (CHUNK_BYTES)
  ) u_step (
    .cfg     (cfg_r),
    .state_i (state_r),
    .item    (in_r),
    .state_o (state_nxt),
    .result  (out_nxt)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.uid_low      <= '0;
      cfg_r.uid_high     <= '0;
      cfg_r.preferred_id <= PREFERRED_RESET;
      cfg_r.static_id    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_UID_LOW:   cfg_r.uid_low      <= cfg_wdata;
        CFG_UID_HIGH:  cfg_r.uid_high     <= cfg_wdata;
        CFG_PREFERRED: cfg_r.preferred_id <= cfg_wdata[6:0];
        CFG_STATIC:    cfg_r.static_id    <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // Pipeline valids and allocation state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= '0;
    end else begin
      if (in_valid && in_ready) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        state_r <= state_nxt;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

/* tb/tb_dynamic_node_id_allocatee_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dynamic_node_id_allocatee_core - allocation client self-checking bench
// Drives ticks and allocation messages through the valid/ready input and
// checks every status transfer against a cycle-free model of the request
// deadline, unique-ID offset and node-ID adoption. Runs directed cases and
// then random traffic under several register settings and idling patterns.
// ----------------------------------------------------------------------------

module tb_dynamic_node_id_allocatee_core;
  import dnia_pkg::*;

  // Item kinds carried in the mode field
  localparam logic MODE_TICK      = 1'b0;
  localparam logic MODE_ALLOC_MSG = 1'b1;

  localparam int unsigned PUSH_OUT_MS = MIN_REQUEST_PERIOD_DEF + FOLLOWUP_DELAY_DEF;
  localparam int unsigned CHUNK_CAP   =
    (CHUNK_BYTES_DEF > MAX_CHUNK) ? MAX_CHUNK : CHUNK_BYTES_DEF;
  localparam int unsigned SEG_ITEMS   = 260;

  // --------------------------------------------------------------------------
  // Scoreboard: allocation model plus queue of status transfers still due
  // --------------------------------------------------------------------------
  class alloc_scoreboard;
    // register copy; unique ID byte 0 in bits 7:0
    logic [127:0] uid;
    logic [6:0]   pref_id;
    logic [6:0]   stat_id;
    // allocation state
    bit           have_id;
    logic [6:0]   own_id;
    logic [4:0]   uid_off;
    logic [31:0]  next_req;

    out_item_t    pending_status[$];
    int           n_errors;
    int           n_in;
    int           n_out;
    int           n_requests;
    int           n_partial;

    function new();
      uid        = '0;
      pref_id    = PREFERRED_RESET;
      stat_id    = '0;
      have_id    = 1'b0;
      own_id     = '0;
      uid_off    = '0;
      next_req   = '0;
      n_errors   = 0;
      n_in       = 0;
      n_out      = 0;
      n_requests = 0;
      n_partial  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_UID_LOW:   uid[63:0]   = val;
        CFG_UID_HIGH:  uid[127:64] = val;
        CFG_PREFERRED: pref_id     = val[6:0];
        CFG_STATIC:    stat_id     = val[6:0];
        default: ;
      endcase
    endfunction

    // Advance the allocation state by one accepted input and queue the status
    function void advance_allocation(in_item_t it);
      out_item_t    r;
      logic [31:0]  push_out;
      logic [3:0]   off;
      logic [127:0] echo;
      int unsigned  left;
      int unsigned  i;
      bit           fixed;
      bit           agree;
      r        = '0;
      fixed    = (stat_id != 7'd0);
      push_out = it.now_ms + 32'(PUSH_OUT_MS);
      echo     = {it.echo_high, it.echo_low};
      if (!(fixed || have_id)) begin
        if (it.mode == MODE_TICK) begin
          // deadline is a plain unsigned compare
          if (it.now_ms >= next_req) begin
            off             = uid_off[3:0];
            left            = UID_LEN - off;
            r.send_request  = 1'b1;
            r.request_head  = {pref_id, (off == 4'd0)};
            r.chunk_len     = 3'((left > CHUNK_CAP) ? CHUNK_CAP : left);
            for (i = 0; i < r.chunk_len; i++)
              r.uid_chunk[8*i +: 8] = uid[8*(off+i) +: 8];
            next_req   = push_out;
            uid_off    = '0;
            n_requests++;
          end
        end else begin
          next_req = push_out;
          if (it.source_node == 7'd0) begin
            // another allocatee is talking
            uid_off = '0;
          end else begin
            agree = (it.echo_len <= UID_LEN);
            for (i = 0; agree && i < it.echo_len; i++)
              if (echo[8*i +: 8] != uid[8*i +: 8]) agree = 1'b0;
            if (!agree) begin
              uid_off = '0;
            end else if (it.echo_len < UID_LEN) begin
              uid_off  = it.echo_len;
              next_req = push_out - 32'(MIN_REQUEST_PERIOD_DEF);
              n_partial++;
            end else if (it.granted_id != 7'd0) begin
              own_id  = it.granted_id;
              have_id = 1'b1;
            end
          end
        end
      end
      r.allocated = fixed || have_id;
      r.node_id   = fixed ? stat_id : (have_id ? own_id : 7'd0);
      pending_status.push_back(r);
      n_in++;
    endfunction

    task report(string msg);
      $display("[%0t] ERROR: %s", $time, msg);
      n_errors++;
    endtask

    task cmp(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("status %0d field %s: got %h, want %h", n_out, name, got, want));
    endtask

    task check_status(out_item_t got);
      out_item_t want;
      n_out++;
      if (pending_status.size() == 0) begin
        report($sformatf("status transfer %h with nothing outstanding", got));
      end else begin
        want = pending_status.pop_front();
        cmp("send_request", 64'(got.send_request), 64'(want.send_request));
        cmp("request_head", 64'(got.request_head), 64'(want.request_head));
        cmp("uid_chunk",    64'(got.uid_chunk),    64'(want.uid_chunk));
        cmp("chunk_len",    64'(got.chunk_len),    64'(want.chunk_len));
        cmp("allocated",    64'(got.allocated),    64'(want.allocated));
        cmp("node_id",      64'(got.node_id),      64'(want.node_id));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  alloc_scoreboard sb;
  logic [31:0]     clock_ms;
  int              send_gap_pct;
  int              stall_pct;
  int              n_settings;

  dynamic_node_id_allocatee_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Transfer monitor on both channels
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.advance_allocation(in_data);
    if (rst_n && out_valid && out_ready) sb.check_status(out_data);
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Item builders
  // --------------------------------------------------------------------------
  // Tick with junk in the fields it ignores
  function automatic in_item_t tick_at(logic [31:0] t);
    in_item_t it;
    it.mode        = MODE_TICK;
    it.now_ms      = t;
    it.source_node = 7'($urandom);
    it.echo_len    = 5'($urandom);
    it.echo_low    = {$urandom, $urandom};
    it.echo_high   = {$urandom, $urandom};
    it.granted_id  = 7'($urandom);
    return it;
  endfunction

  // Allocation message echoing the local unique ID up to elen, junk beyond;
  // spoil flips one echoed byte
  function automatic in_item_t alloc_msg(logic [31:0] t, logic [6:0] src,
                                         logic [4:0] elen, logic [6:0] grant,
                                         bit spoil);
    in_item_t     it;
    logic [127:0] echo;
    int unsigned  i;
    int unsigned  k;
    echo = {$urandom, $urandom, $urandom, $urandom};
    for (i = 0; i < elen && i < UID_LEN; i++) echo[8*i +: 8] = sb.uid[8*i +: 8];
    if (spoil && elen != 0 && elen <= UID_LEN) begin
      k = $urandom_range(0, elen - 1);
      echo[8*k +: 8] = echo[8*k +: 8] ^ 8'($urandom_range(1, 255));
    end
    it.mode        = MODE_ALLOC_MSG;
    it.now_ms      = t;
    it.source_node = src;
    it.echo_len    = elen;
    it.echo_low    = echo[63:0];
    it.echo_high   = echo[127:64];
    it.granted_id  = grant;
    return it;
  endfunction

  // Mostly well-formed exchanges, some broken ones and noise; never adopts
  function automatic in_item_t next_random_item();
    in_item_t    it;
    int unsigned pick;
    int unsigned elen;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      clock_ms = sb.next_req + $urandom_range(0, 40);
      it = tick_at(clock_ms);
    end else if (pick < 45) begin
      clock_ms = clock_ms + $urandom_range(0, 700);
      it = tick_at(clock_ms);
    end else if (pick < 70) begin
      clock_ms = clock_ms + $urandom_range(1, 100);
      case ($urandom_range(0, 3))
        0:       elen = 6;
        1:       elen = 12;
        2:       elen = $urandom_range(0, 16);
        default: elen = 16;
      endcase
      it = alloc_msg(clock_ms, 7'($urandom_range(1, 127)), 5'(elen),
                     (elen == UID_LEN) ? 7'd0 : 7'($urandom), 1'b0);
    end else if (pick < 80) begin
      it = alloc_msg(clock_ms, 7'($urandom_range(1, 127)), 5'($urandom_range(1, 16)),
                     7'($urandom), 1'b1);
    end else if (pick < 88) begin
      it = alloc_msg(clock_ms, 7'd0, 5'($urandom_range(0, 16)), 7'($urandom), 1'b0);
    end else if (pick < 95) begin
      it = alloc_msg(clock_ms, 7'($urandom), 5'($urandom_range(17, 31)), 7'($urandom), 1'b0);
    end else begin
      clock_ms = $urandom();
      it = tick_at(clock_ms);
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Driving tasks; all start and end at a falling edge
  // --------------------------------------------------------------------------
  task send_item(in_item_t it);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Hold the input until every outstanding status has arrived
  task drain();
    in_valid <= 1'b0;
    while (sb.pending_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task load_config(logic [63:0] lo, logic [63:0] hi, logic [6:0] pref, logic [6:0] stat);
    drain();
    write_reg(CFG_UID_LOW, lo);
    write_reg(CFG_UID_HIGH, hi);
    write_reg(CFG_PREFERRED, 64'(pref));
    write_reg(CFG_STATIC, 64'(stat));
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  task set_idling(int pattern);
    case (pattern)
      0:       begin send_gap_pct = 0;  stall_pct = 0;  end
      1:       begin send_gap_pct = 60; stall_pct = 0;  end
      2:       begin send_gap_pct = 0;  stall_pct = 60; end
      default: begin send_gap_pct = 18; stall_pct = 18; end
    endcase
  endtask

  task run_random(int n, bit mid_pause);
    int k;
    for (k = 0; k < n; k++) begin
      if (mid_pause && k == n / 2) drain();
      send_item(next_random_item());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_item_t raw;
    int       seg;
    int       patterns[6];
    sb           = new();
    clock_ms     = '0;
    n_settings   = 0;
    send_gap_pct = 0;
    stall_pct    = 0;
    patterns     = '{0, 1, 2, 3, 2, 1};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: full offset walk, special echoes and deadline wrap
    load_config(64'h8877_6655_4433_2211, 64'hFFEE_DDCC_BBAA_9900, 7'd127, 7'd0);
    send_item(tick_at(32'd0));
    send_item(tick_at(32'd999));
    send_item(alloc_msg(32'd1000, 7'd0, 5'd16, 7'd127, 1'b0));
    send_item(alloc_msg(32'd1100, 7'd127, 5'd6, 7'd0, 1'b0));
    send_item(tick_at(32'd1500));
    send_item(alloc_msg(32'd1600, 7'd5, 5'd12, 7'd0, 1'b0));
    send_item(tick_at(32'd2000));
    send_item(alloc_msg(32'd2100, 7'd9, 5'd15, 7'd0, 1'b0));
    send_item(tick_at(32'd2500));
    // full echo granting ID zero is not taken
    send_item(alloc_msg(32'd2600, 7'd3, 5'd16, 7'd0, 1'b0));
    // oversized echo lengths
    send_item(alloc_msg(32'd2700, 7'd3, 5'd17, 7'd127, 1'b0));
    send_item(alloc_msg(32'd2800, 7'd127, 5'd31, 7'd1, 1'b0));
    send_item(alloc_msg(32'd2900, 7'd1, 5'd0, 7'd127, 1'b0));
    send_item(alloc_msg(32'd3000, 7'd2, 5'd6, 7'd0, 1'b1));
    // deadline sums wrapping past 2^32
    send_item(tick_at(32'hFFFF_FFFF));
    send_item(tick_at(32'd0));
    send_item(alloc_msg(32'hFFFF_FE00, 7'd127, 5'd6, 7'd0, 1'b0));
    send_item(tick_at(32'hFFFF_FFFF));
    raw = '1;
    send_item(raw);
    raw.mode = MODE_TICK;
    send_item(raw);
    send_item(tick_at(32'd0));

    // Random traffic over several register settings and idling patterns
    clock_ms = 32'd4000;
    for (seg = 0; seg < 6; seg++) begin
      case (seg)
        0: load_config({$urandom, $urandom}, {$urandom, $urandom}, 7'd0, 7'd0);
        1: load_config('1, '1, 7'd127, 7'd0);
        2: load_config({$urandom, $urandom}, {$urandom, $urandom}, 7'd69, 7'd127);
        3: load_config('0, '0, 7'($urandom), 7'd0);
        default: load_config({$urandom, $urandom}, {$urandom, $urandom},
                             7'($urandom), 7'd0);
      endcase
      set_idling(patterns[seg]);
      run_random(SEG_ITEMS, seg == 1);
    end

    // Closing exchange: request, full echo with a real grant, then held ID
    set_idling(3);
    clock_ms = sb.next_req;
    send_item(tick_at(clock_ms));
    clock_ms = clock_ms + 32'd10;
    send_item(alloc_msg(clock_ms, 7'd42, 5'd16, 7'($urandom_range(1, 127)), 1'b0));
    run_random(40, 1'b0);
    load_config(sb.uid[63:0], sb.uid[127:64], sb.pref_id, 7'd1);
    run_random(20, 1'b0);
    load_config(sb.uid[63:0], sb.uid[127:64], sb.pref_id, 7'd0);
    run_random(20, 1'b0);

    drain();
    repeat (10) @(negedge clk);

    $display("Summary: %0d transfers in, %0d status transfers checked, %0d requests",
             sb.n_in, sb.n_out, sb.n_requests);
    $display("Summary: %0d partial echoes, %0d register settings incl. static ID and adoption",
             sb.n_partial, n_settings);
    if (sb.n_errors == 0 && sb.pending_status.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
